### rtl/gic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_pkg: shared types and constants
// Value and count widths, interval record and result record for the interval cover block.
// ----------------------------------------------------------------------------
package gic_pkg;

    localparam int VAL_W   = 31;
    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic signed [VAL_W-1:0] hi;
        logic signed [VAL_W-1:0] lo;
    } span_t;

    // result of one run, handed from the scan engine to the output stage
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               ok;
    } cover_res_t;

endpackage

### rtl/gic_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_cmp: shared signed compare unit
// One signed less-than compare, used for the left-end compares of the sort and the scan.
// ----------------------------------------------------------------------------
module gic_cmp (
    input  logic signed [gic_pkg::VAL_W-1:0] a,
    input  logic signed [gic_pkg::VAL_W-1:0] b,
    output logic                             lt
);

    // a < b
    assign lt = a < b;

endmodule

### rtl/greedy_interval_cover.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_interval_cover: greedy minimum interval cover
// Collects intervals, sorts them by left end, then scans greedily.
// ----------------------------------------------------------------------------
// Loading takes one interval per cycle while s_tready is high. The item
// with tlast starts a run that sorts the n stored intervals with an
// insertion sort over the interval memory and then walks the sorted store
// once; the left-end compares of both go through one shared signed compare
// unit, the other compares are separate logic. s_tready stays low
// for the whole run. The result leaves through its own register on the m_
// side, so loading of the next set goes on while it waits; a run that ends
// while the previous result still waits holds until that result is taken.
// ----------------------------------------------------------------------------
module greedy_interval_cover #(
    parameter int MAX_INTERVALS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // left_end[30:0], right_end[61:31], zero fill
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // interval_count[10:0], covered[11], overflowed[12]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data
);

    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int NW = $clog2(MAX_INTERVALS + 1);
    localparam int VW = gic_pkg::VAL_W;
    localparam int CW = gic_pkg::COUNT_W;

    typedef enum logic [9:0] {
        ST_LOAD   = 10'b0000000001,
        ST_SOUTER = 10'b0000000010,
        ST_SRDA   = 10'b0000000100,
        ST_SCUR   = 10'b0000001000,
        ST_SRDB   = 10'b0000010000,
        ST_SCMP   = 10'b0000100000,
        ST_SPUT   = 10'b0001000000,
        ST_GRD    = 10'b0010000000,
        ST_GCHK   = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // interval memory
    gic_pkg::span_t mem [MAX_INTERVALS];
    gic_pkg::span_t rd_reg;
    logic           we;
    logic [AW-1:0]  waddr, raddr;
    gic_pkg::span_t wdata;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    logic signed [VW-1:0] tstart_reg, tend_reg;
    logic [NW-1:0]        n_reg, n_next;
    logic                 ovf_reg, ovf_next;
    logic [NW-1:0]        a_reg, a_next, b_reg, b_next;
    gic_pkg::span_t       cur_reg, cur_next;
    logic signed [VW-1:0] start_reg, start_next, reach_reg, reach_next;
    logic                 found_reg, found_next;
    logic [CW-1:0]        used_reg, used_next;
    gic_pkg::cover_res_t  res_reg, res_next;
    logic                 mv_reg, mv_next;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tstart_reg <= '0;
            tend_reg   <= '0;
        end else if (cfg_we) begin
            if (cfg_index == 1'b0) begin
                tstart_reg <= cfg_data;
            end else begin
                tend_reg <= cfg_data;
            end
        end
    end

    // shared compare unit
    logic signed [VW-1:0] ca, cb;
    logic                 lt;
    gic_cmp u_cmp (.a(ca), .b(cb), .lt(lt));

    logic s_acc;
    assign s_tready = (state_reg == ST_LOAD);
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        n_next = n_reg; ovf_next = ovf_reg; a_next = a_reg; b_next = b_reg;
        cur_next = cur_reg; start_next = start_reg; reach_next = reach_reg;
        found_next = found_reg; used_next = used_reg; res_next = res_reg;
        mv_next = mv_reg;
        we = 1'b0;
        waddr = n_reg[AW-1:0];
        wdata.lo = s_tdata[30:0];
        wdata.hi = s_tdata[61:31];
        raddr = a_reg[AW-1:0];
        ca = '0; cb = '0;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    if (n_reg < NW'(MAX_INTERVALS)) begin
                        we = 1'b1;
                        n_next = n_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        a_next = NW'(1);
                        state_next = ST_SOUTER;
                    end
                end
            end
            // next element to insert
            ST_SOUTER: begin
                if (a_reg < n_reg) begin
                    state_next = ST_SRDA;
                end else begin
                    a_next = '0;
                    start_next = tstart_reg;
                    used_next = '0;
                    found_next = 1'b0;
                    state_next = ST_GRD;
                end
            end
            ST_SRDA: begin
                state_next = ST_SCUR;
            end
            ST_SCUR: begin
                cur_next = rd_reg;
                b_next = a_reg;
                state_next = ST_SRDB;
            end
            // read entry b-1
            ST_SRDB: begin
                if (b_reg == '0) begin
                    state_next = ST_SPUT;
                end else begin
                    raddr = AW'(b_reg - 1'b1);
                    state_next = ST_SCMP;
                end
            end
            // shift while lo of b-1 > cur.lo
            ST_SCMP: begin
                ca = cur_reg.lo;
                cb = rd_reg.lo;
                if (lt) begin
                    we = 1'b1;
                    waddr = b_reg[AW-1:0];
                    wdata = rd_reg;
                    b_next = b_reg - 1'b1;
                    state_next = ST_SRDB;
                end else begin
                    state_next = ST_SPUT;
                end
            end
            ST_SPUT: begin
                we = 1'b1;
                waddr = b_reg[AW-1:0];
                wdata = cur_reg;
                a_next = a_reg + 1'b1;
                state_next = ST_SOUTER;
            end
            // greedy scan: issue read of entry a
            ST_GRD: begin
                state_next = ST_GCHK;
            end
            ST_GCHK: begin
                ca = start_reg;
                cb = rd_reg.lo;
                if (a_reg < n_reg && !lt) begin
                    // candidate: keep farthest right end
                    if (!found_reg || rd_reg.hi > reach_reg) begin
                        reach_next = rd_reg.hi;
                    end
                    found_next = 1'b1;
                    a_next = a_reg + 1'b1;
                    state_next = ST_GRD;
                end else if (!found_reg || reach_reg < start_reg) begin
                    res_next.ok = 1'b0;
                    res_next.count = '0;
                    state_next = ST_OUT;
                end else begin
                    if (used_reg != gic_pkg::COUNT_MAX) begin
                        used_next = used_reg + 1'b1;
                    end
                    if (reach_reg >= tend_reg) begin
                        res_next.ok = 1'b1;
                        res_next.count = (used_reg != gic_pkg::COUNT_MAX) ?
                                         used_reg + 1'b1 : used_reg;
                        state_next = ST_OUT;
                    end else if (a_reg >= n_reg) begin
                        res_next.ok = 1'b0;
                        res_next.count = '0;
                        state_next = ST_OUT;
                    end else begin
                        start_next = reach_reg;
                        found_next = 1'b0;
                        state_next = ST_GCHK;
                    end
                end
            end
            ST_OUT: begin
                if (!mv_reg) begin
                    mv_next = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    logic                ovf_out_reg;
    gic_pkg::cover_res_t res_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            if (state_reg == ST_OUT && !mv_reg) begin
                n_reg   <= '0;
                ovf_reg <= 1'b0;
            end else begin
                n_reg   <= n_next;
                ovf_reg <= ovf_next;
            end
        end
        a_reg <= a_next; b_reg <= b_next; cur_reg <= cur_next;
        start_reg <= start_next; reach_reg <= reach_next;
        found_reg <= found_next; used_reg <= used_next; res_reg <= res_next;
        // output register, loaded when the result slot is free
        if (state_reg == ST_OUT && !mv_reg) begin
            ovf_out_reg <= ovf_reg;
            res_out_reg <= res_reg;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {3'b000, ovf_out_reg, res_out_reg.ok, res_out_reg.count};

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> !s_tready)
        else $error("ready during run");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= NW'(MAX_INTERVALS))
        else $error("store count overrun");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
    a_uncov_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[CW]) |-> (m_tdata[CW-1:0] == '0))
        else $error("count nonzero on uncovered");
`endif

endmodule
